@@ rtl/core/flag_escape_byte_deframer_core_assert.svh @@
// assertion macros for the flag/escape byte deframer
`ifndef FLAG_ESCAPE_BYTE_DEFRAMER_CORE_ASSERT_SVH
`define FLAG_ESCAPE_BYTE_DEFRAMER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define FEDF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked outside reset
`define FEDF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FEDF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FEDF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/fedf_pkg.sv @@
package fedf_pkg;

  // framing codes
  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_OF_ESC  = 8'h5D;
  localparam logic [7:0] ESC_OF_FLAG = 8'h5E;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 13;

  // frame length limit after reset
  localparam int unsigned LIMIT_RESET = 4096;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

endpackage

@@ rtl/core/flag_escape_byte_deframer_core.sv @@
// a result word is valid in the cycle after the input word that releases it
// throughput: one input word per cycle unless out_ready stalls the single output
//   register holding a result; a word is taken if out_ready drains it that cycle
// reset (rst, synchronous, active high): hunting for a flag, no held byte,
//   no output pending, frame length limit 4096 (clamped to MAX_FRAME)
`include "flag_escape_byte_deframer_core_assert.svh"

module flag_escape_byte_deframer_core
  import fedf_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 4096
) (
  input  logic  clk,
  input  logic  rst,
  // configuration write channel
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  len_t  cfg_data,
  // input channel
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t rx_byte,
  // output channel
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t out_byte,
  output logic  last,
  output logic  frame_error,
  output len_t  frame_len
);

  // counter width: enough for MAX_FRAME, never more than the 13-bit config range
  localparam int unsigned CNT_FULL_W = $clog2(MAX_FRAME + 1);
  localparam int unsigned CNT_W      = (CNT_FULL_W < LEN_W) ? CNT_FULL_W : LEN_W;
  localparam int unsigned LIM_RST    = (LIMIT_RESET > MAX_FRAME) ? MAX_FRAME : LIMIT_RESET;

  typedef logic [CNT_W-1:0] cnt_t;

  // state
  cnt_t  limit;
  logic  in_frame;
  logic  escape_pending;
  byte_t held_byte;
  logic  held_valid;
  logic  error_seen;
  cnt_t  byte_count;

  logic  in_frame_next;
  logic  escape_pending_next;
  byte_t held_byte_next;
  logic  held_valid_next;
  logic  error_seen_next;
  cnt_t  byte_count_next;

  logic  emit;
  byte_t emit_byte;
  logic  emit_last;
  logic  emit_error;
  len_t  emit_len;

  logic  take_en;
  byte_t take_byte;
  logic  accept;
  cnt_t  cfg_limit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // clamp the written limit to 1..MAX_FRAME
  always_comb begin
    if (cfg_data == '0) begin
      cfg_limit = cnt_t'(1);
    end else if (32'(cfg_data) > MAX_FRAME) begin
      cfg_limit = cnt_t'(MAX_FRAME);
    end else begin
      cfg_limit = cnt_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= cnt_t'(LIM_RST);
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_limit;
    end
  end

  // decode one received byte
  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    error_seen_next     = error_seen;
    byte_count_next     = byte_count;
    emit                = 1'b0;
    emit_byte           = held_byte;
    emit_last           = 1'b0;
    emit_error          = 1'b0;
    emit_len            = '0;
    take_en             = 1'b0;
    take_byte           = rx_byte;

    if (!in_frame) begin
      if (rx_byte == FLAG_BYTE) begin
        in_frame_next       = 1'b1;
        escape_pending_next = 1'b0;
        held_byte_next      = '0;
        held_valid_next     = 1'b0;
        error_seen_next     = 1'b0;
        byte_count_next     = '0;
      end
    end else if (rx_byte == FLAG_BYTE) begin
      // closing flag releases the held byte as the last one
      emit       = held_valid;
      emit_last  = 1'b1;
      emit_error = error_seen || escape_pending;
      emit_len   = len_t'(byte_count);
      escape_pending_next = 1'b0;
      held_byte_next      = '0;
      held_valid_next     = 1'b0;
      error_seen_next     = 1'b0;
      byte_count_next     = '0;
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (rx_byte == ESC_OF_ESC) begin
        take_en   = 1'b1;
        take_byte = ESC_BYTE;
      end else if (rx_byte == ESC_OF_FLAG) begin
        take_en   = 1'b1;
        take_byte = FLAG_BYTE;
      end else begin
        error_seen_next = 1'b1;
      end
    end else if (rx_byte == ESC_BYTE) begin
      escape_pending_next = 1'b1;
    end else begin
      take_en = 1'b1;
    end

    // payload byte: drop on overlength, else push out the held byte
    if (take_en) begin
      if (byte_count >= limit) begin
        error_seen_next = 1'b1;
      end else begin
        emit            = held_valid;
        held_byte_next  = take_byte;
        held_valid_next = 1'b1;
        byte_count_next = byte_count + cnt_t'(1);
      end
    end
  end

  // deframer state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      error_seen     <= 1'b0;
      byte_count     <= '0;
    end else if (accept) begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      error_seen     <= error_seen_next;
      byte_count     <= byte_count_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte    <= emit_byte;
      last        <= emit_last;
      frame_error <= emit_error;
      frame_len   <= emit_len;
    end
  end

  // checks
  `FEDF_ASSERT_IMP(a_mid_word_clean, clk, rst, out_valid && !last,
                   !frame_error && frame_len == '0)
  `FEDF_ASSERT_NXT(a_hunt_silent, clk, rst, accept && !in_frame, !out_valid)
  `FEDF_ASSERT_IMP(a_held_counted, clk, rst, held_valid, byte_count != '0)
  `FEDF_ASSERT_IMP(a_hunt_empty, clk, rst, !in_frame,
                   !held_valid && !escape_pending && byte_count == '0)

endmodule

@@ tb/deframe_checker.sv @@
`timescale 1ns / 100ps

module deframe_checker
  import fedf_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 4096
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_valid,
  input  logic  cfg_ready,
  input  len_t  cfg_data,
  input  logic  in_valid,
  input  logic  in_ready,
  input  byte_t rx_byte,
  input  logic  out_valid,
  input  logic  out_ready,
  input  byte_t out_byte,
  input  logic  last,
  input  logic  frame_error,
  input  len_t  frame_len,
  output int    fail_count,
  output int    pending_words,
  output int    frames_closed,
  output int    frames_flagged
);

  typedef struct packed {
    byte_t data;
    logic  eof;
    logic  bad;
    len_t  count;
  } payload_word_t;

  // unstuffed payload words still owed by the block
  payload_word_t unstuffed_words[$];

  // mirror of the deframer state
  len_t  limit_reg;
  logic  in_frame;
  logic  esc_pending;
  byte_t held_byte;
  logic  held_valid;
  logic  error_seen;
  len_t  kept_count;

  // limit in force, zero acts as one and the top is clamped
  function automatic int unsigned active_limit();
    int unsigned lim;
    lim = limit_reg;
    if (lim == 0) lim = 1;
    if (lim > MAX_FRAME) lim = MAX_FRAME;
    return lim;
  endfunction

  function automatic void clear_frame();
    esc_pending = 1'b0;
    held_byte   = '0;
    held_valid  = 1'b0;
    error_seen  = 1'b0;
    kept_count  = '0;
  endfunction

  // keep one payload byte, releasing the one held back
  function automatic void keep_byte(input byte_t d);
    if (kept_count >= active_limit()) begin
      error_seen = 1'b1;
    end else begin
      if (held_valid) unstuffed_words.push_back('{held_byte, 1'b0, 1'b0, len_t'(0)});
      held_byte  = d;
      held_valid = 1'b1;
      kept_count = kept_count + 1'b1;
    end
  endfunction

  // one raw line byte through the flag and escape rules
  function automatic void unstuff_byte(input byte_t b);
    if (!in_frame) begin
      if (b == FLAG_BYTE) begin
        in_frame = 1'b1;
        clear_frame();
      end
    end else if (b == FLAG_BYTE) begin
      if (esc_pending) error_seen = 1'b1;
      if (held_valid) unstuffed_words.push_back('{held_byte, 1'b1, error_seen, kept_count});
      clear_frame();
    end else if (esc_pending) begin
      esc_pending = 1'b0;
      if (b == ESC_OF_ESC) keep_byte(ESC_BYTE);
      else if (b == ESC_OF_FLAG) keep_byte(FLAG_BYTE);
      else error_seen = 1'b1;
    end else if (b == ESC_BYTE) begin
      esc_pending = 1'b1;
    end else begin
      keep_byte(b);
    end
  endfunction

  // compare one output word with the oldest expectation
  function automatic void check_word();
    payload_word_t want;
    if (unstuffed_words.size() == 0) begin
      $error("output word 0x%02h arrived with nothing expected", out_byte);
      fail_count++;
    end else begin
      want = unstuffed_words.pop_front();
      if (out_byte !== want.data) begin
        $error("out_byte mismatch: expected 0x%02h, got 0x%02h", want.data, out_byte);
        fail_count++;
      end
      if (last !== want.eof) begin
        $error("last mismatch: expected %0d, got %0d", want.eof, last);
        fail_count++;
      end
      if (frame_error !== want.bad) begin
        $error("frame_error mismatch: expected %0d, got %0d", want.bad, frame_error);
        fail_count++;
      end
      if (frame_len !== want.count) begin
        $error("frame_len mismatch: expected %0d, got %0d", want.count, frame_len);
        fail_count++;
      end
      if (want.eof) begin
        frames_closed++;
        if (want.bad) frames_flagged++;
      end
    end
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      limit_reg = len_t'(LIMIT_RESET);
      in_frame  = 1'b0;
      clear_frame();
      unstuffed_words.delete();
      fail_count     = 0;
      frames_closed  = 0;
      frames_flagged = 0;
    end else begin
      if (out_valid && out_ready) check_word();
      if (in_valid && in_ready) unstuff_byte(rx_byte);
      // a word taken at the same edge still sees the old limit
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
    end
    pending_words = unstuffed_words.size();
  end

endmodule

@@ tb/flag_escape_byte_deframer_core_tb.sv @@
`timescale 1ns / 100ps

module flag_escape_byte_deframer_core_tb;
  import fedf_pkg::*;

  localparam int NUM_PHASES   = 9;
  localparam int PHASE_WORDS  = 165;
  localparam int SETTLE_MAX   = 20000;

  logic  clk;
  logic  rst       = 1'b1;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  len_t  cfg_data  = '0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  byte_t rx_byte   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  byte_t out_byte;
  logic  last;
  logic  frame_error;
  len_t  frame_len;

  int fail_count;
  int pending_words;
  int frames_closed;
  int frames_flagged;

  int unsigned in_idle_pct  = 25;
  int unsigned out_idle_pct = 50;
  len_t        cur_limit    = len_t'(LIMIT_RESET);
  int          items_sent   = 0;
  int          phase_items  = 0;
  logic        drain_stuck  = 1'b0;
  len_t        phase_limits[NUM_PHASES];

  // opening sequence: noise before the first flag, flag run, escapes,
  // bad escape, dangling escape, empty frame with an error, escape followed by escape
  byte_t opening_words[25] = '{
    ESC_BYTE, 8'h33, ESC_OF_FLAG,
    FLAG_BYTE, FLAG_BYTE,
    8'h00, 8'hFF, ESC_BYTE, ESC_OF_ESC, ESC_BYTE, ESC_OF_FLAG, FLAG_BYTE,
    8'h41, ESC_BYTE, 8'h33, FLAG_BYTE,
    8'h55, ESC_BYTE, FLAG_BYTE,
    ESC_BYTE, FLAG_BYTE,
    ESC_BYTE, ESC_BYTE, ESC_OF_ESC, FLAG_BYTE
  };

  flag_escape_byte_deframer_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last        (last),
    .frame_error (frame_error),
    .frame_len   (frame_len)
  );

  deframe_checker deframe_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last           (last),
    .frame_error    (frame_error),
    .frame_len      (frame_len),
    .fail_count     (fail_count),
    .pending_words  (pending_words),
    .frames_closed  (frames_closed),
    .frames_flagged (frames_flagged)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // one raw word on the input channel, with random gaps in front
  task automatic send_raw(input byte_t b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    phase_items++;
  endtask

  // payload byte, stuffed when it collides with a code
  task automatic send_payload(input byte_t d);
    if (d == FLAG_BYTE) begin
      send_raw(ESC_BYTE);
      send_raw(ESC_OF_FLAG);
    end else if (d == ESC_BYTE) begin
      send_raw(ESC_BYTE);
      send_raw(ESC_OF_ESC);
    end else begin
      send_raw(d);
    end
  endtask

  // bias toward the framing codes
  function automatic byte_t pick_byte();
    case ($urandom_range(7))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      2:       return ESC_OF_ESC;
      3:       return ESC_OF_FLAG;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // stop sending and wait until every owed word has come out or the wait gives up
  task automatic let_block_settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0 && waited < SETTLE_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (pending_words != 0) drain_stuck = 1'b1;
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input len_t v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = v;
  endtask

  // one random frame, mostly well formed, sometimes broken
  task automatic random_chunk();
    int unsigned kind;
    int unsigned span;
    byte_t       bad_code;
    kind = $urandom_range(99);
    span = (cur_limit == 0) ? 1 : ((cur_limit > 24) ? 24 : cur_limit);
    if (kind < 75) begin
      repeat ($urandom_range(0, span + 3)) send_payload(byte_t'($urandom_range(255)));
      send_raw(FLAG_BYTE);
    end else if (kind < 81) begin
      // bad escape inside a frame
      do bad_code = byte_t'($urandom_range(255));
      while (bad_code == ESC_OF_ESC || bad_code == ESC_OF_FLAG || bad_code == FLAG_BYTE);
      repeat ($urandom_range(0, 3)) send_payload(pick_byte());
      send_raw(ESC_BYTE);
      send_raw(bad_code);
      repeat ($urandom_range(0, 3)) send_payload(pick_byte());
      send_raw(FLAG_BYTE);
    end else if (kind < 87) begin
      // escape right before the closing flag
      repeat ($urandom_range(0, 4)) send_payload(pick_byte());
      send_raw(ESC_BYTE);
      send_raw(FLAG_BYTE);
    end else if (kind < 93) begin
      repeat ($urandom_range(2, 4)) send_raw(FLAG_BYTE);
    end else begin
      repeat ($urandom_range(1, 12)) send_raw(pick_byte());
    end
  endtask

  // stimulus and verdict
  initial begin
    phase_limits = '{13'd0, 13'd1, 13'd2, 13'h1FFF, 13'd5, 13'd0, 13'd4096, 13'd0, 13'd3};
    phase_limits[5] = len_t'($urandom_range(1, 40));
    phase_limits[7] = len_t'($urandom_range(6, 24));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed words under the reset limit
    foreach (opening_words[i]) send_raw(opening_words[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin in_idle_pct = 25; out_idle_pct = 50; end
        1: begin in_idle_pct = 50; out_idle_pct = 25; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      let_block_settle();
      write_limit(phase_limits[p]);
      phase_items = 0;
      while (phase_items < PHASE_WORDS) random_chunk();
    end

    let_block_settle();
    $display("covered %0d input words over %0d limit settings and three idle mixes",
             items_sent, NUM_PHASES + 1);
    $display("%0d frames closed, %0d of them flagged", frames_closed, frames_flagged);
    if (!drain_stuck && fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
